FILE: design/nsf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter package
// Shared sizes, character codes, and the structs passed between the
// front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package nsf_pkg;

	localparam int BUFFER_DEPTH = 128;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int PAIR_W       = ADDR_W - 1;
	localparam int MEM_AW       = ADDR_W + 1;
	localparam int MEM_DEPTH    = 2 ** MEM_AW;
	localparam int ID_W         = 40;
	localparam int QDEPTH       = 2;

	// "GPRMC", first character in the top byte.
	localparam logic [ID_W-1:0] SENTENCE_ID_RESET = 40'h4750524D43;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam logic [2:0] POS_IDLE    = 3'd0;
	localparam logic [2:0] POS_LAST_ID = 3'd5;
	localparam logic [2:0] POS_BODY    = 3'd6;

	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// Identifier character expected at header position 1..5.
	function automatic logic [7:0] id_char(input logic [ID_W-1:0] id, input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd1:    c = id[39:32];
			3'd2:    c = id[31:24];
			3'd3:    c = id[23:16];
			3'd4:    c = id[15:8];
			3'd5:    c = id[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: design/nsf_front.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter front end
// Matches the sentence identifier, writes kept bytes into the current
// buffer bank and hands a finished sentence to the job queue.
// ----------------------------------------------------------------------------
module nsf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [nsf_pkg::ID_W-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 rx_byte,
	input  logic                       q_full,
	output nsf_pkg::push_t             push,
	output nsf_pkg::wr_t               wr
);

	localparam int LW = nsf_pkg::LEN_W;
	localparam int AW = nsf_pkg::ADDR_W;

	logic [nsf_pkg::ID_W-1:0] sentence_id_q;
	logic [2:0]               pos_q, pos_n;
	logic                     matched_q, matched_n;
	logic                     failed_q, failed_n;
	logic [LW-1:0]            len_q, len_n;
	logic                     bank_q, bank_n;
	logic                     take;
	logic                     keep;
	logic [7:0]               want;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign want     = nsf_pkg::id_char(sentence_id_q, pos_q);

	always_comb begin
		pos_n      = pos_q;
		matched_n  = matched_q;
		failed_n   = failed_q;
		len_n      = len_q;
		bank_n     = bank_q;
		keep       = 1'b0;
		push.valid = 1'b0;
		push.job   = '{bank: bank_q, len: len_q};
		if (take) begin
			if (rx_byte == nsf_pkg::CH_DOLLAR) begin
				pos_n     = 3'd1;
				matched_n = 1'b0;
				failed_n  = 1'b0;
				len_n     = LW'(1);
				keep      = 1'b1;
			end else if (rx_byte == nsf_pkg::CH_STAR) begin
				if (matched_q && len_q != '0) begin
					push.valid = 1'b1;
					bank_n     = ~bank_q;
				end
				pos_n     = nsf_pkg::POS_IDLE;
				matched_n = 1'b0;
				failed_n  = 1'b0;
				len_n     = '0;
			end else if (pos_q != nsf_pkg::POS_IDLE && pos_q != nsf_pkg::POS_BODY) begin
				failed_n = failed_q || (rx_byte != want);
				keep     = len_q < LW'(nsf_pkg::BUFFER_DEPTH);
				pos_n    = pos_q + 3'd1;
				if (pos_q == nsf_pkg::POS_LAST_ID) begin
					matched_n = !failed_n;
				end
			end else if (pos_q == nsf_pkg::POS_BODY && matched_q) begin
				keep = len_q < LW'(nsf_pkg::BUFFER_DEPTH);
			end
			if (keep && rx_byte != nsf_pkg::CH_DOLLAR) begin
				len_n = len_q + LW'(1);
			end
		end
	end

	// A dollar always lands at entry zero of the current bank.
	always_comb begin
		wr.en   = keep;
		wr.data = rx_byte;
		if (rx_byte == nsf_pkg::CH_DOLLAR) begin
			wr.addr = {bank_q, AW'(0)};
		end else begin
			wr.addr = {bank_q, len_q[AW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentence_id_q <= nsf_pkg::SENTENCE_ID_RESET;
			pos_q         <= nsf_pkg::POS_IDLE;
			matched_q     <= 1'b0;
			failed_q      <= 1'b0;
			len_q         <= '0;
			bank_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				sentence_id_q <= cfg_data;
			end
			pos_q     <= pos_n;
			matched_q <= matched_n;
			failed_q  <= failed_n;
			len_q     <= len_n;
			bank_q    <= bank_n;
		end
	end

`ifndef ASSERT_OFF
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> push.job.len != '0)
		else $error("front pushed an empty sentence");
`endif

endmodule

FILE: design/nsf_jobq.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter job queue
// Two-entry queue of finished sentences (bank and length) between the
// front end and the back end.
// ----------------------------------------------------------------------------
module nsf_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  nsf_pkg::push_t push,
	input  logic           pop,
	output nsf_pkg::job_t  head,
	output logic           empty,
	output logic           full
);

	nsf_pkg::job_t job_q [nsf_pkg::QDEPTH];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    count_q;

	assign empty = count_q == 2'd0;
	assign full  = count_q == 2'd2;
	assign head  = job_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			job_q[wptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue popped while empty");
`endif

endmodule

FILE: design/nsf_back.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter back end
// Holds the two-bank sentence store and plays a queued sentence out as
// byte pairs, each read from the store and then held at the output until taken.
// ----------------------------------------------------------------------------
module nsf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  nsf_pkg::wr_t  wr,
	input  nsf_pkg::job_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    first_byte,
	output logic [7:0]    second_byte,
	output logic          second_valid,
	output logic          last_pair
);

	localparam int LW = nsf_pkg::LEN_W;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_READ = 3'b010,
		BK_OUT  = 3'b100
	} bk_state_t;

	logic [7:0]                  mem [nsf_pkg::MEM_DEPTH];
	bk_state_t                   state_q, state_n;
	logic [nsf_pkg::PAIR_W-1:0]  pair_q, pair_n;
	logic [7:0]                  rd0_q, rd1_q;
	logic                        has2_q, last_q;
	logic                        rd_en;
	logic [LW-1:0]               idx_odd;
	logic [LW:0]                 idx_next;
	logic                        has2, more;

	assign rd_en    = state_q == BK_READ;
	assign idx_odd  = LW'({pair_q, 1'b1});
	assign idx_next = {1'b0, idx_odd} + (LW + 1)'(1);
	assign has2     = idx_odd < head.len;
	assign more     = idx_next < {1'b0, head.len};

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd0_q  <= mem[{head.bank, pair_q, 1'b0}];
			rd1_q  <= mem[{head.bank, pair_q, 1'b1}];
			has2_q <= has2;
			last_q <= !more;
		end
	end

	always_comb begin
		state_n = state_q;
		pair_n  = pair_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pair_n  = '0;
					state_n = BK_READ;
				end
			end
			BK_READ: begin
				state_n = BK_OUT;
			end
			BK_OUT: begin
				if (out_ready) begin
					if (last_q) begin
						pop     = 1'b1;
						state_n = BK_IDLE;
					end else begin
						pair_n  = pair_q + nsf_pkg::PAIR_W'(1);
						state_n = BK_READ;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pair_q  <= '0;
		end else begin
			state_q <= state_n;
			pair_q  <= pair_n;
		end
	end

	assign out_valid    = state_q == BK_OUT;
	assign first_byte   = rd0_q;
	assign second_byte  = has2_q ? rd1_q : 8'h00;
	assign second_valid = has2_q;
	assign last_pair    = last_q;

`ifndef ASSERT_OFF
	// The front end must never write into the bank being played out.
	a_bank_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && !q_empty) |-> wr.addr[nsf_pkg::MEM_AW-1] != head.bank)
		else $error("store write hit the bank being read");
	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !q_empty)
		else $error("back end busy without a queued sentence");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_pair) |=> state_q == BK_IDLE)
		else $error("back end did not return to idle after last pair");
`endif

endmodule

FILE: design/nmea_sentence_filter.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter
// Picks sentences with one configured identifier out of a received byte
// stream and sends them out as byte pairs.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, rx_byte): one received byte per word.
// A dollar starts a sentence; the five bytes after it are compared with
// the identifier in cfg_data (GPRMC after reset). A matching sentence is
// kept from the dollar up to the star; on the star it is queued for output.
// Output channel (out_valid/out_ready): one word per kept pair, the final
// word flagged by last_pair; second_valid marks a real second byte.
// The input takes one byte per cycle. It stalls only while two finished
// sentences are waiting, since each one holds one of the two store banks.
// With the back end idle, a queued sentence goes from idle to a store read
// and then to output; each pair is read from the store and then presented
// as an output word.
// While the receiver stalls the current word holds and the front end keeps
// filling the other bank. Reset restores the GPRMC identifier, empties the
// queue and returns both ends to idle; the store needs no clearing.
// cfg_we writes the identifier; the user must only use it while the block is idle (not enforced by the block).
// ----------------------------------------------------------------------------
module nmea_sentence_filter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [nsf_pkg::ID_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               rx_byte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               first_byte,
	output logic [7:0]               second_byte,
	output logic                     second_valid,
	output logic                     last_pair
);

	nsf_pkg::push_t push;
	nsf_pkg::wr_t   wr;
	nsf_pkg::job_t  head;
	logic           q_empty;
	logic           q_full;
	logic           pop;

	nsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.wr       (wr)
	);

	nsf_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	nsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_byte   (first_byte),
		.second_byte  (second_byte),
		.second_valid (second_valid),
		.last_pair    (last_pair)
	);

endmodule
